>>> src/arpt_pkg.sv
// Types and constants shared by the region table modules.
`timescale 1ns / 1ps
package arpt_pkg;
    localparam int ADDR_W = 32;
    localparam int FLAG_W = 4;

    localparam int FLAG_READ  = 0;
    localparam int FLAG_WRITE = 1;
    localparam int FLAG_EXEC  = 2;
    localparam int FLAG_STACK = 3;

    localparam logic [2:0] CMD_INSERT = 3'd0;
    localparam logic [2:0] CMD_LOOKUP = 3'd1;
    localparam logic [2:0] CMD_VERIFY = 3'd2;
    localparam logic [2:0] CMD_FAULT  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_BAD  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] FC_READ_ABSENT  = 2'd0;
    localparam logic [1:0] FC_READ_PRESENT = 2'd1;

    localparam logic CFG_USER_BASE = 1'b0;
    localparam logic CFG_USER_TOP  = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] start_a;
        logic [ADDR_W-1:0] end_a;
        logic [FLAG_W-1:0] flags;
    } t_entry;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [ADDR_W-1:0] qend;
        logic              ins_en;
        t_entry            new_entry;
    } t_query;

    // Handed from one cell to its right-hand neighbor.
    typedef struct packed {
        t_entry entry;
        logic   valid;
        logic   move;
    } t_link;
endpackage

>>> src/arpt_cell.sv
// One table slot: holds a region, matches the query and shifts right on insert.
`timescale 1ns / 1ps
module arpt_cell
    import arpt_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_first,
    input  logic   i_valid,
    input  t_query i_query,
    input  t_link  i_prev,
    output t_link  o_link,
    output logic   o_hit,
    output logic   o_ovl
);
    t_entry r_entry;
    logic   w_move;
    logic   w_slot;

    assign w_move = i_valid && (r_entry.start_a > i_query.addr);
    assign o_hit  = i_valid && (r_entry.start_a <= i_query.addr)
                    && (i_query.addr < r_entry.end_a);
    assign o_ovl  = w_move && (r_entry.start_a < i_query.qend);
    assign w_slot = (i_first || (i_prev.valid && !i_prev.move)) && (w_move || !i_valid);

    assign o_link.entry = r_entry;
    assign o_link.valid = i_valid;
    assign o_link.move  = w_move;

    always_ff @(posedge i_clk) begin
        if (i_query.ins_en) begin
            if (!i_first && i_prev.move) begin
                r_entry <= i_prev.entry;
            end else if (w_slot) begin
                r_entry <= i_query.new_entry;
            end
        end
    end
endmodule

>>> src/address_region_permission_table.sv
// Top level of the address region permission table.
`timescale 1ns / 1ps
// A sorted table of up to MAX_REGIONS non-overlapping regions held in a row of
// cells, one region per cell; every cell compares the current query address in
// parallel, and an insert shifts the cells above the new slot one place right.
// Each command is registered on its input transfer and runs in S_EXEC; its
// result is written when S_EXEC finishes, and the state then returns to S_IDLE
// for the next command. Verify stays in S_EXEC, walking the regions in turn.
// One command is in flight at a time; the result register frees the input side
// as soon as the result is written, but a command cannot finish while an earlier
// result still waits for its transfer. PAGE_BYTES must be a power of two.
module address_region_permission_table
    import arpt_pkg::*;
#(
    parameter int MAX_REGIONS = 16,
    parameter int PAGE_BYTES  = 4096
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [31:0]       i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [2:0]        i_cmd,
    input  logic [31:0]       i_address,
    input  logic [31:0]       i_length,
    input  logic [3:0]        i_flags,
    input  logic              i_write_access,
    input  logic [1:0]        i_fault_code,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [1:0]        o_status,
    output logic              o_allowed,
    output logic [31:0]       o_region_start,
    output logic [31:0]       o_region_end,
    output logic [3:0]        o_region_flags,
    output logic [31:0]       o_page_address,
    output logic              o_map_writable,
    output logic [31:0]       o_fault_count
);
    localparam int CNT_W = $clog2(MAX_REGIONS + 1);
    localparam logic [33:0] PG_MASK = 34'(PAGE_BYTES - 1);
    localparam logic [32:0] PG33    = 33'(PAGE_BYTES);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    t_state            r_state;
    logic [31:0]       r_base, r_top, r_fcnt;
    logic [CNT_W-1:0]  r_count;
    logic [2:0]        r_cmd;
    logic [31:0]       r_qaddr, r_qend;
    logic [3:0]        r_flags;
    logic              r_wr;
    logic [1:0]        r_code;
    logic              r_bad;

    logic              r_ovalid;
    logic [1:0]        r_status;
    logic              r_allowed, r_mapw;
    logic [31:0]       r_rs, r_re, r_pa;
    logic [3:0]        r_rf;

    // Range checks at transfer time.
    logic [32:0] w_sum;
    logic [33:0] w_up;
    logic [33:0] w_e;
    logic [31:0] w_s;
    logic        w_ins_bad, w_ver_bad;

    always_comb begin
        w_sum = {1'b0, i_address} + {1'b0, i_length};
        w_up  = {1'b0, w_sum} + PG_MASK;
        w_e   = w_up & ~PG_MASK;
        w_s   = i_address & ~PG_MASK[31:0];
        w_ins_bad = w_sum[32] || (w_e[33:32] != 2'b00) || (w_s < r_base)
                    || ({2'b00, w_s} >= w_e) || (w_e > {2'b00, r_top});
        w_ver_bad = w_sum[32] || (i_address < r_base) || ({1'b0, i_address} >= w_sum)
                    || (w_sum > {1'b0, r_top});
    end

    // Cell row.
    t_query                w_query;
    t_link  [MAX_REGIONS:0] w_link;
    logic [MAX_REGIONS-1:0] w_hit, w_ovl;
    logic                   w_ins_en;

    assign w_link[0] = '0;
    assign w_query.addr = r_qaddr;
    assign w_query.qend = r_qend;
    assign w_query.ins_en = w_ins_en;
    assign w_query.new_entry.start_a = r_qaddr;
    assign w_query.new_entry.end_a = r_qend;
    assign w_query.new_entry.flags = r_flags;

    for (genvar g = 0; g < MAX_REGIONS; g++) begin : g_cell
        arpt_cell u_cell (
            .i_clk   (i_clk),
            .i_first (g == 0),
            .i_valid (CNT_W'(g) < r_count),
            .i_query (w_query),
            .i_prev  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_hit   (w_hit[g]),
            .o_ovl   (w_ovl[g])
        );
    end

    // At most one cell hits, so an OR picks its entry.
    t_entry w_sel;
    always_comb begin
        w_sel = '0;
        for (int k = 0; k < MAX_REGIONS; k++) begin
            if (w_hit[k]) w_sel = w_sel | w_link[k+1].entry;
        end
    end

    logic        w_any_hit, w_any_ovl, w_full;
    assign w_any_hit = |w_hit;
    assign w_any_ovl = |w_ovl;
    assign w_full    = (r_count == CNT_W'(MAX_REGIONS));

    function automatic logic fault_legal(input logic [1:0] code, input logic [3:0] fl);
        logic res;
        res = 1'b0;
        case (code)
            FC_READ_ABSENT:  res = fl[FLAG_READ] || fl[FLAG_EXEC];
            FC_READ_PRESENT: res = 1'b0;
            default:         res = fl[FLAG_WRITE];
        endcase
        return res;
    endfunction

    // Execute.
    logic        w_done, w_step, w_ok, w_fault_ok, w_guard;
    logic [1:0]  w_st;
    logic        w_reg_out;
    logic        w_out_free, w_fin;

    assign w_out_free = !r_ovalid || i_ready;
    assign w_guard = ({1'b0, r_qaddr} < ({1'b0, w_sel.start_a} + PG33));
    assign w_fault_ok = fault_legal(r_code, w_sel.flags);

    always_comb begin
        w_done = 1'b1;
        w_step = 1'b0;
        w_ok = 1'b0;
        w_st = ST_BAD;
        w_reg_out = 1'b0;
        unique case (r_cmd)
            CMD_INSERT: begin
                if (r_bad || w_any_hit) begin
                    w_st = ST_BAD;
                end else if (w_full) begin
                    w_st = ST_FULL;
                end else if (!w_any_ovl) begin
                    w_st = ST_OK;
                    w_ok = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                w_ok = w_any_hit;
                w_st = w_any_hit ? ST_OK : ST_BAD;
                w_reg_out = w_any_hit;
            end
            CMD_VERIFY: begin
                if (r_bad) begin
                    w_st = ST_BAD;
                end else if (r_qaddr >= r_qend) begin
                    w_st = ST_OK;
                    w_ok = 1'b1;
                end else if (!w_any_hit || !w_sel.flags[r_wr ? FLAG_WRITE : FLAG_READ]
                             || (r_wr && w_sel.flags[FLAG_STACK] && w_guard)) begin
                    w_st = ST_BAD;
                end else begin
                    w_done = 1'b0;
                    w_step = 1'b1;
                end
            end
            CMD_FAULT: begin
                w_reg_out = w_any_hit;
                w_ok = w_any_hit && w_fault_ok;
                w_st = w_ok ? ST_OK : ST_BAD;
            end
            CMD_CLEAR: begin
                w_ok = 1'b1;
                w_st = ST_OK;
            end
            default: w_st = ST_BAD;
        endcase
    end

    assign w_fin = (r_state == S_EXEC) && w_done && w_out_free;
    assign w_ins_en = w_fin && (r_cmd == CMD_INSERT) && w_ok;
    assign o_ready = (r_state == S_IDLE);

    logic [31:0] n_fcnt;
    assign n_fcnt = (r_cmd == CMD_FAULT) ? r_fcnt + 32'd1 : r_fcnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_base   <= 32'h0020_0000;
            r_top    <= 32'hB000_0000;
            r_fcnt   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_USER_BASE) r_base <= i_cfg_data;
                else r_top <= i_cfg_data;
            end
            if (w_fin) r_ovalid <= 1'b1;
            else if (o_valid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) r_state <= S_EXEC;
                end
                S_EXEC: begin
                    if (w_fin) begin
                        r_state  <= S_IDLE;
                        r_fcnt   <= n_fcnt;
                        if (w_ins_en) r_count <= r_count + CNT_W'(1);
                        if (r_cmd == CMD_CLEAR) r_count <= '0;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Command and result payload.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid) begin
            r_cmd   <= i_cmd;
            r_flags <= i_flags;
            r_wr    <= i_write_access;
            r_code  <= i_fault_code;
            if (i_cmd == CMD_INSERT) begin
                r_qaddr <= w_s;
                r_qend  <= w_e[31:0];
                r_bad   <= w_ins_bad;
            end else begin
                r_qaddr <= i_address;
                r_qend  <= w_sum[31:0];
                r_bad   <= w_ver_bad;
            end
        end else if (r_state == S_EXEC && w_step) begin
            r_qaddr <= w_sel.end_a;
        end
        if (w_fin) begin
            r_status  <= w_st;
            r_allowed <= w_ok;
            r_mapw    <= (r_cmd == CMD_FAULT) && w_ok && w_sel.flags[FLAG_WRITE];
            r_pa      <= (r_cmd == CMD_FAULT) ? (r_qaddr & ~PG_MASK[31:0]) : 32'd0;
            if (w_ins_en) begin
                r_rs <= r_qaddr;
                r_re <= r_qend;
                r_rf <= r_flags;
            end else if (w_reg_out) begin
                r_rs <= w_sel.start_a;
                r_re <= w_sel.end_a;
                r_rf <= w_sel.flags;
            end else begin
                r_rs <= '0;
                r_re <= '0;
                r_rf <= '0;
            end
        end
    end

    assign o_valid        = r_ovalid;
    assign o_status       = r_status;
    assign o_allowed      = r_allowed;
    assign o_region_start = r_rs;
    assign o_region_end   = r_re;
    assign o_region_flags = r_rf;
    assign o_page_address = r_pa;
    assign o_map_writable = r_mapw;
    assign o_fault_count  = r_fcnt;
endmodule
